[hw/rtl/hpt_pkg.sv]
package hpt_pkg;

	// field and register widths
	localparam int unsigned PeriodW  = 15;
	localparam int unsigned TimeoutW = 16;
	localparam int unsigned CountW   = 16;

	// divider: 20-bit dividend covers one million, 16-bit divisor covers both divisions
	localparam int unsigned DivW    = 20;
	localparam int unsigned DvsrW   = 16;
	localparam int unsigned DivCntW = $clog2(DivW);

	localparam logic [DivW-1:0]    UsPerSecond  = DivW'(1000000);
	localparam logic [DivCntW-1:0] DivLastCnt   = DivCntW'(DivW - 1);
	localparam logic [CountW-1:0]  EdgeWrap     = CountW'(32764);
	localparam logic [PeriodW-1:0] PeriodReset  = PeriodW'(75);
	localparam logic [TimeoutW-1:0] TimeoutReset = TimeoutW'(26668);

	// register indexes, selected by paddr[2]
	localparam logic RegTickPeriod = 1'b0;
	localparam logic RegTimeout    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_RATE,
		ST_RELOAD,
		ST_DIV_TICK,
		ST_SCALE,
		ST_EMIT
	} hpt_state_t;

	typedef struct packed {
		logic accept;
		logic div_load_rate;
		logic div_step;
		logic div_load_tick;
		logic scale;
		logic emit;
	} hpt_cmd_t;

	typedef struct packed {
		logic update;
		logic div_last;
		logic out_free;
	} hpt_status_t;

	// 60 * q modulo 2^16, as 64q - 4q
	function automatic logic [CountW-1:0] times_sixty(input logic [CountW-1:0] q);
		logic [CountW-1:0] q64;
		logic [CountW-1:0] q4;
		q64 = q << 6;
		q4  = q << 2;
		return q64 - q4;
	endfunction

endpackage

[hw/rtl/hpt_cfg.sv]
module hpt_cfg
	import hpt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output logic [PeriodW-1:0]  tick_period,
	output logic [TimeoutW-1:0] timeout_ticks
);

	logic [PeriodW-1:0]  period_q;
	logic [TimeoutW-1:0] timeout_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// register writes, word select on address bit 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PeriodReset;
			timeout_q <= TimeoutReset;
		end else if (wr_en) begin
			if (paddr[2] == RegTickPeriod) begin
				period_q <= pwdata[PeriodW-1:0];
			end else begin
				timeout_q <= pwdata[TimeoutW-1:0];
			end
		end
	end

	// read back
	always_comb begin
		if (paddr[2] == RegTimeout) begin
			prdata = {{(32-TimeoutW){1'b0}}, timeout_q};
		end else begin
			prdata = {{(32-PeriodW){1'b0}}, period_q};
		end
	end

	assign tick_period   = period_q;
	assign timeout_ticks = timeout_q;

endmodule

[hw/rtl/hpt_ctrl.sv]
module hpt_ctrl
	import hpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hall_valid,
	output logic        hall_stall,
	input  hpt_status_t status,
	output hpt_cmd_t    cmd
);

	hpt_state_t state_q;
	hpt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		hall_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				hall_stall = 1'b0;
				if (hall_valid) begin
					cmd.accept = 1'b1;
					if (status.update) begin
						cmd.div_load_rate = 1'b1;
						state_d           = ST_DIV_RATE;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_DIV_RATE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_RELOAD;
				end
			end
			ST_RELOAD: begin
				cmd.div_load_tick = 1'b1;
				state_d           = ST_DIV_TICK;
			end
			ST_DIV_TICK: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/hpt_dp.sv]
module hpt_dp
	import hpt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  hpt_cmd_t            cmd,
	output hpt_status_t         status,
	input  logic                hall_level,
	input  logic [PeriodW-1:0]  tick_period,
	input  logic [TimeoutW-1:0] timeout_ticks,
	input  logic                result_stall,
	output logic                result_valid,
	output logic [CountW-1:0]   speed_value,
	output logic [CountW-1:0]   rev_count
);

	// tachometer state
	logic              prev_q;
	logic              running_q;
	logic [CountW-1:0] tick_q;
	logic [CountW-1:0] edge_q;
	logic [CountW-1:0] speed_q;
	logic [CountW-1:0] upd_q;
	logic [CountW-1:0] div_tick_q;

	// divider
	logic [DvsrW-1:0]   rem_q;
	logic [DivW-1:0]    quot_q;
	logic [DvsrW-1:0]   dvsr_q;
	logic [DivCntW-1:0] cnt_q;

	// output register
	logic              out_valid_q;
	logic [CountW-1:0] out_speed_q;
	logic [CountW-1:0] out_rev_q;

	logic              edge_seen;
	logic [CountW-1:0] tick_inc;
	logic [CountW-1:0] edge_base;
	logic [CountW-1:0] edge_inc;
	logic              update;
	logic [DvsrW:0]    trial;
	logic [DvsrW:0]    diff;
	logic              fits;

	// per-tick edge and counter logic
	assign edge_seen = hall_level ^ prev_q;
	assign tick_inc  = tick_q + CountW'(1);
	assign edge_base = (edge_q >= EdgeWrap) ? '0 : edge_q;
	assign edge_inc  = edge_base + CountW'(1);
	assign update    = running_q & edge_seen & (edge_inc != '0) & ~edge_inc[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= 1'b0;
			running_q  <= 1'b0;
			tick_q     <= '0;
			edge_q     <= '0;
			speed_q    <= '0;
			upd_q      <= '0;
		end else begin
			if (cmd.accept) begin
				prev_q <= hall_level;
				if (!running_q) begin
					tick_q    <= '0;
					edge_q    <= '0;
					speed_q   <= '0;
					upd_q     <= '0;
					running_q <= edge_seen;
				end else begin
					if (tick_q > timeout_ticks) begin
						running_q <= 1'b0;
					end
					tick_q <= update ? '0 : tick_inc;
					edge_q <= edge_seen ? edge_inc : edge_base;
					if (update) begin
						upd_q <= upd_q + CountW'(1);
					end
				end
			end
			if (cmd.scale) begin
				speed_q <= times_sixty(quot_q[CountW-1:0]);
			end
		end
	end

	// tick count held for the second division
	always_ff @(posedge clk) begin
		if (cmd.accept && update) begin
			div_tick_q <= tick_inc;
		end
	end

	// restoring divider, one quotient bit a cycle
	assign trial = {rem_q, quot_q[DivW-1]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign fits  = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load_rate) begin
			rem_q  <= '0;
			quot_q <= UsPerSecond;
			dvsr_q <= {{(DvsrW-PeriodW){1'b0}}, tick_period};
			cnt_q  <= DivLastCnt;
		end else if (cmd.div_load_tick) begin
			rem_q  <= '0;
			quot_q <= {{(DivW-CountW){1'b0}}, quot_q[CountW-1:0]};
			dvsr_q <= div_tick_q;
			cnt_q  <= DivLastCnt;
		end else if (cmd.div_step) begin
			rem_q  <= fits ? diff[DvsrW-1:0] : trial[DvsrW-1:0];
			quot_q <= {quot_q[DivW-2:0], fits};
			cnt_q  <= cnt_q - DivCntW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_speed_q <= speed_q;
			out_rev_q   <= upd_q;
		end
	end

	assign status.update   = update;
	assign status.div_last = (cnt_q == '0);
	assign status.out_free = ~out_valid_q | ~result_stall;

	assign result_valid = out_valid_q;
	assign speed_value  = out_speed_q;
	assign rev_count    = out_rev_q;

endmodule

[hw/rtl/hall_pulse_tachometer_unit.sv]
// channel   | handshake                  | payload
// hall      | hall_valid / hall_stall    | hall_level
// result    | result_valid / result_stall| speed_value, rev_count
// config    | apb rd/wr, pready tied high| tick_period_us @0x0, timeout_ticks @0x4
//
// a tick without a speed update goes from accept via emit to the result register
// a tick that updates the speed makes two 20-step passes of the one
// restoring divider (one million by the period, then by the tick count) plus
// reload, scaling and load of the result register
// one tick in flight; the next is taken once its result sits in the output
// register, so a stalled result beat holds only the following tick
// arst_n clears the tick, edge and revolution counters, the mode and the output
// valid; registers reset to 75 and 26668
module hall_pulse_tachometer_unit
	import hpt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hall_valid,
	output logic                hall_stall,
	input  logic                hall_level,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [CountW-1:0]   speed_value,
	output logic [CountW-1:0]   rev_count,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [PeriodW-1:0]  tick_period;
	logic [TimeoutW-1:0] timeout_ticks;
	hpt_cmd_t            cmd;
	hpt_status_t         status;

	hpt_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.tick_period   (tick_period),
		.timeout_ticks (timeout_ticks)
	);

	hpt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.hall_valid (hall_valid),
		.hall_stall (hall_stall),
		.status     (status),
		.cmd        (cmd)
	);

	hpt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.hall_level    (hall_level),
		.tick_period   (tick_period),
		.timeout_ticks (timeout_ticks),
		.result_stall  (result_stall),
		.result_valid  (result_valid),
		.speed_value   (speed_value),
		.rev_count     (rev_count)
	);

endmodule

[hw/rtl/hpt_checker.sv]
module hpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        hall_valid,
	input logic        hall_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [15:0] speed_value,
	input logic [15:0] rev_count,
	input logic        psel,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] prdata
);

	// an accepted tick leaves the input side busy in the next cycle
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		hall_valid && !hall_stall |=> hall_stall)
		else $error("input taken in the cycle after an accepted beat");

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(speed_value)
			&& $stable(rev_count))
		else $error("stalled result beat changed");

	// a new result only appears out of a busy cycle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(hall_stall))
		else $error("result appeared without work in progress");

	// register read data carries no bits beyond the register width
	a_read_width: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite |-> (prdata[31:16] == 16'h0) && (paddr[2] || !prdata[15]))
		else $error("read data wider than register");

endmodule

bind hall_pulse_tachometer_unit hpt_checker u_hpt_checker (.*);

[tb/hall_pulse_tachometer_unit_tb.sv]
`timescale 1ns / 1ps

module hall_pulse_tachometer_unit_tb;
	import hpt_pkg::*;

	localparam logic [2:0] ADDR_TICK_PERIOD = 3'h0;
	localparam logic [2:0] ADDR_TIMEOUT     = 3'h4;
	localparam logic [15:0] EDGE_WRAP_AT    = 16'd32764;
	localparam int unsigned US_PER_SEC      = 1000000;
	localparam int unsigned SEC_PER_MIN     = 60;
	localparam int DRAIN_CYCLES             = 60;
	localparam int HOLD_AFTER_BEATS         = 150;
	localparam int HOLD_CYCLES              = 400;
	localparam int MAX_REPORTS              = 10;
	localparam int LIMIT_NS                 = 5_000_000;
	localparam int N_DIRECTED               = 28;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_SET_PERIOD,
		OP_SET_TIMEOUT
	} stim_op_t;

	typedef struct packed {
		stim_op_t    op;
		logic [15:0] arg;
		logic        typed;
		logic [15:0] want_speed;
		logic [15:0] want_revs;
	} stim_row_t;

	typedef struct packed {
		logic [15:0] speed;
		logic [15:0] revs;
	} reading_t;

	typedef struct packed {
		logic        prev_lvl;
		logic        spinning;
		logic [15:0] ticks;
		logic [15:0] edges;
		logic [15:0] speed;
		logic [15:0] revs;
	} tacho_t;

	logic              clk;
	logic              arst_n;
	logic              hall_valid;
	logic              hall_stall;
	logic              hall_level;
	logic              result_valid;
	logic              result_stall;
	logic [CountW-1:0] speed_value;
	logic [CountW-1:0] rev_count;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// mirror of the block: registers and tachometer state
	logic [14:0] cfg_period;
	logic [15:0] cfg_timeout;
	tacho_t      tacho;

	reading_t reading_q[$];
	int       mismatches;
	int       beats_out;
	int       burst_left;

	// directed stimulus: typed expectations only where plain to see
	stim_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{OP_TICK,        16'd0,     1'b1, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b1, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd0,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd0,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd0,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd0,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b0, 16'd0, 16'd0},
		'{OP_SET_PERIOD,  16'd5,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd0,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b0, 16'd0, 16'd0},
		'{OP_SET_PERIOD,  16'd0,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd0,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b0, 16'd0, 16'd0},
		'{OP_SET_PERIOD,  16'd32767, 1'b0, 16'd0, 16'd0},
		'{OP_SET_TIMEOUT, 16'd0,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b1, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b1, 16'd0, 16'd0},
		'{OP_SET_TIMEOUT, 16'd65535, 1'b0, 16'd0, 16'd0},
		'{OP_SET_PERIOD,  16'd16,    1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd0,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd0,     1'b0, 16'd0, 16'd0},
		'{OP_TICK,        16'd1,     1'b0, 16'd0, 16'd0}
	};

	hall_pulse_tachometer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.hall_valid   (hall_valid),
		.hall_stall   (hall_stall),
		.hall_level   (hall_level),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.speed_value  (speed_value),
		.rev_count    (rev_count),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#LIMIT_NS;
		$display("Simulation FAILED");
		$finish;
	end

	// one hall tick through the tachometer, returns speed and revolutions
	function automatic reading_t tacho_tick(input logic lvl);
		logic        edge_seen;
		logic [15:0] rate;
		logic [15:0] q;
		reading_t    r;
		edge_seen = (lvl != tacho.prev_lvl);
		if (!tacho.spinning) begin
			tacho.ticks = '0;
			tacho.edges = '0;
			tacho.speed = '0;
			tacho.revs  = '0;
			if (edge_seen)
				tacho.spinning = 1'b1;
		end else begin
			if (tacho.ticks > cfg_timeout)
				tacho.spinning = 1'b0;
			if (tacho.edges >= EDGE_WRAP_AT)
				tacho.edges = '0;
			tacho.ticks = tacho.ticks + 16'd1;
			if (edge_seen) begin
				tacho.edges = tacho.edges + 16'd1;
				if (tacho.edges != 16'd0 && !tacho.edges[0]) begin
					tacho.revs = tacho.revs + 16'd1;
					rate = (cfg_period == '0) ? 16'hFFFF : 16'(US_PER_SEC / cfg_period);
					q = (tacho.ticks == '0) ? 16'hFFFF : rate / tacho.ticks;
					tacho.speed = 16'(SEC_PER_MIN * q);
					tacho.ticks = '0;
				end
			end
		end
		tacho.prev_lvl = lvl;
		r.speed = tacho.speed;
		r.revs  = tacho.revs;
		return r;
	endfunction

	// hall beat with burst and gap idling, expectation queued on accept
	task automatic send_tick(input logic lvl, input logic typed, input logic [15:0] ws,
			input logic [15:0] wr);
		int       gap;
		reading_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				hall_valid <= 1'b0;
				hall_level <= 1'($urandom_range(0, 1));
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		hall_valid <= 1'b1;
		hall_level <= lvl;
		@(posedge clk);
		while (hall_stall) @(posedge clk);
		r = tacho_tick(lvl);
		if (typed) begin
			r.speed = ws;
			r.revs  = wr;
		end
		reading_q.push_back(r);
	endtask

	// let the block run dry before touching registers or finishing
	task automatic settle();
		hall_valid <= 1'b0;
		while (reading_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write, setup then access
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_TICK_PERIOD)
			cfg_period = data[14:0];
		else
			cfg_timeout = data[15:0];
	endtask

	// random phase: mostly regular hall waveforms, some noise
	task automatic spin_phase(input logic [14:0] period, input logic [15:0] limit,
			input int n_ticks);
		int   sent;
		int   half;
		int   runs;
		logic lvl;
		apb_write(ADDR_TICK_PERIOD, {17'd0, period});
		apb_write(ADDR_TIMEOUT, {16'd0, limit});
		sent = 0;
		while (sent < n_ticks) begin
			if ($urandom_range(0, 99) < 20) begin
				send_tick(1'($urandom_range(0, 1)), 1'b0, '0, '0);
				sent++;
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					half = $urandom_range(9, 80);
					runs = $urandom_range(2, 3);
				end else begin
					half = $urandom_range(1, 8);
					runs = $urandom_range(2, 10);
				end
				lvl = tacho.prev_lvl;
				repeat (runs) begin
					lvl = ~lvl;
					repeat (half) begin
						send_tick(lvl, 1'b0, '0, '0);
						sent++;
					end
				end
			end
		end
	endtask

	task automatic report_mismatch(input string what, input reading_t want, input reading_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t mismatch (%s): speed exp %0d got %0d, revs exp %0d got %0d",
				$realtime, what, want.speed, got.speed, want.revs, got.revs);
	endtask

	// result checker
	always @(posedge clk) begin
		reading_t want;
		reading_t got;
		if (arst_n && result_valid && !result_stall) begin
			beats_out++;
			got.speed = speed_value;
			got.revs  = rev_count;
			if (reading_q.size() == 0) begin
				report_mismatch("unexpected beat", '0, got);
			end else begin
				want = reading_q.pop_front();
				if (want != got)
					report_mismatch("field", want, got);
			end
		end
	end

	// result side stalls, with one long hold-off to back the block up
	initial begin
		int mode;
		int mode_left;
		int run_left;
		int hold_left;
		bit held;
		bit stalled;
		mode      = 0;
		mode_left = 0;
		run_left  = 0;
		hold_left = 0;
		held      = 1'b0;
		stalled   = 1'b0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!held && beats_out >= HOLD_AFTER_BEATS) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				result_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				case (mode)
					0: begin
						result_stall <= 1'b0;
					end
					1: begin
						result_stall <= ($urandom_range(0, 99) < 30);
					end
					default: begin
						if (run_left == 0) begin
							stalled  = ~stalled;
							run_left = $urandom_range(1, 12);
						end
						run_left--;
						result_stall <= stalled;
					end
				endcase
			end
		end
	end

	// main sequence
	initial begin
		int i;
		arst_n     <= 1'b0;
		hall_valid <= 1'b0;
		hall_level <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		mismatches  = 0;
		beats_out   = 0;
		burst_left  = 0;
		cfg_period  = 15'd75;
		cfg_timeout = 16'd26668;
		tacho       = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (i = 0; i < N_DIRECTED; i++) begin
			case (directed_rows[i].op)
				OP_TICK: begin
					send_tick(directed_rows[i].arg[0], directed_rows[i].typed,
						directed_rows[i].want_speed, directed_rows[i].want_revs);
				end
				OP_SET_PERIOD: begin
					apb_write(ADDR_TICK_PERIOD, {16'd0, directed_rows[i].arg});
				end
				default: begin
					apb_write(ADDR_TIMEOUT, {16'd0, directed_rows[i].arg});
				end
			endcase
		end

		// random phases over several register settings
		spin_phase(15'd75, 16'd26668, 100);
		spin_phase(15'd16, 16'd1, 80);
		spin_phase(15'd32767, 16'd65000, 100);
		spin_phase(15'd0, 16'd0, 60);
		spin_phase(15'd9, 16'd30, 100);
		spin_phase(15'($urandom_range(1, 32767)), 16'($urandom_range(1, 300)), 100);
		spin_phase(15'($urandom_range(1, 32767)), 16'($urandom_range(1, 300)), 100);

		settle();
		if (mismatches == 0 && reading_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
